// ----- rtl/cbe_pkg.sv -----
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared widths, constants, types and helpers for the cubic bezier easing
// block.
// ----------------------------------------------------------------------------
package cbe_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int NEWTON_STEPS = 8;
  localparam int BISECT_STEPS = 20;

  localparam int IN_W   = 19;
  localparam int OUT_W  = 20;
  localparam int MODE_W = 3;
  localparam int ACC_W  = 32;
  localparam int U_W    = FRAC_BITS + 3;
  localparam int PROD_W = ACC_W + U_W;
  localparam int QB     = FRAC_BITS + 4;
  localparam int LH_W   = FRAC_BITS + 2;
  localparam int REM_W  = ACC_W + FRAC_BITS;
  localparam int DSH_W  = ACC_W + QB;
  localparam int UD_W   = QB + 3;
  localparam int IT_MAX = (NEWTON_STEPS > BISECT_STEPS) ? NEWTON_STEPS : BISECT_STEPS;
  localparam int IT_W   = $clog2(IT_MAX);
  localparam int DC_W   = $clog2(QB);

  localparam logic signed [ACC_W-1:0] FX_ONE = ACC_W'(64'd1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] K42 =
    ACC_W'((64'd42 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [ACC_W-1:0] K58 =
    ACC_W'((64'd58 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [IN_W-1:0] ONE_IN = IN_W'(64'd1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(64'd1 << (OUT_W - 1));

  localparam logic [MODE_W-1:0] MODE_STEP        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EASE_IN     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EASE_OUT    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EASE_IN_OUT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BEZIER      = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_DIRECT, S_EVX, S_XCHK, S_EVS, S_SCHK,
    S_DIV, S_NUPD, S_BINIT, S_EVY, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_INIT_X, OP_INIT_SX, OP_INIT_Y, OP_MUL,
    OP_ADD_XB, OP_ADD_XC, OP_ADD_2XB, OP_ADD_YB, OP_ADD_YC, OP_ADD_ZERO,
    OP_SAVE_ERR, OP_DIV_START, OP_DIV_STEP, OP_NEWTON_UPD,
    OP_BIS_INIT, OP_BIS_UPD, OP_OUT_Y, OP_OUT_DIRECT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic curve;
    logic x_eq_t;
    logic slope_zero;
    logic u_in_range;
    logic out_busy;
  } status_t;

  function automatic logic signed [IN_W-1:0] clamp01(input logic signed [IN_W-1:0] v);
    if (v < 0) return '0;
    if (v > ONE_IN) return ONE_IN;
    return v;
  endfunction

endpackage

// ----- rtl/cubic_bezier_easing.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_easing
// Eased progress from a time value and a cubic bezier timing curve.
// ----------------------------------------------------------------------------
// Step/linear modes output directly; curve modes run Newton steps, each
// evaluating x(u) and its slope and dividing with the 1-bit/cycle divider,
// with bisection steps as fallback; all curve evaluations share one
// multiplier. One item at a time; a new item is taken while the result waits
// in the output register. Synchronous active-low reset clears the controller
// and the output valid; no memories.
module cubic_bezier_easing (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic        [cbe_pkg::MODE_W-1:0] in_mode,
  input  logic signed [cbe_pkg::IN_W-1:0]   in_time_in,
  input  logic signed [cbe_pkg::IN_W-1:0]   in_ctrl_x1,
  input  logic signed [cbe_pkg::IN_W-1:0]   in_ctrl_y1,
  input  logic signed [cbe_pkg::IN_W-1:0]   in_ctrl_x2,
  input  logic signed [cbe_pkg::IN_W-1:0]   in_ctrl_y2,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [cbe_pkg::OUT_W-1:0]  out_eased_value
);
  import cbe_pkg::*;

  cmd_t    cmd;
  status_t status;

  cbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cbe_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .mode        (in_mode),
    .time_in     (in_time_in),
    .ctrl_x1     (in_ctrl_x1),
    .ctrl_y1     (in_ctrl_y1),
    .ctrl_x2     (in_ctrl_x2),
    .ctrl_y2     (in_ctrl_y2),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .eased_value (out_eased_value)
  );

endmodule

// ----- rtl/cbe_datapath.sv -----
// ----------------------------------------------------------------------------
// cbe_datapath
// Coefficient setup, shared rounding multiplier, restoring divider, Newton
// and bisection registers, output register.
// ----------------------------------------------------------------------------
module cbe_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cbe_pkg::cmd_t                       cmd,
  output cbe_pkg::status_t                    status,
  input  logic        [cbe_pkg::MODE_W-1:0]   mode,
  input  logic signed [cbe_pkg::IN_W-1:0]     time_in,
  input  logic signed [cbe_pkg::IN_W-1:0]     ctrl_x1,
  input  logic signed [cbe_pkg::IN_W-1:0]     ctrl_y1,
  input  logic signed [cbe_pkg::IN_W-1:0]     ctrl_x2,
  input  logic signed [cbe_pkg::IN_W-1:0]     ctrl_y2,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [cbe_pkg::OUT_W-1:0]    eased_value
);
  import cbe_pkg::*;

  logic signed [ACC_W-1:0]  xa_r, xb_r, xc_r, ya_r, yb_r, yc_r;
  logic signed [ACC_W-1:0]  acc_r, err_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [U_W-1:0]    t_r, u_r;
  logic        [LH_W-1:0]   lo_r, hi_r;
  logic        [REM_W-1:0]  rem_r;
  logic        [DSH_W-1:0]  dsh_r;
  logic        [QB-1:0]     q_r;
  logic                     ovf_r, qneg_r, curve_r, step_r;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  out_val_r;

  // load-time setup
  logic signed [IN_W-1:0]  t_c;
  logic signed [ACC_W-1:0] p1x, p2x, p1y, p2y;
  logic signed [ACC_W-1:0] ax_c, bx_c, cx_c, ay_c, by_c, cy_c;

  always_comb begin
    t_c = clamp01(time_in);
    p1x = '0;
    p2x = FX_ONE;
    p1y = '0;
    p2y = FX_ONE;
    case (mode)
      MODE_EASE_IN: begin
        p1x = K42;
      end
      MODE_EASE_OUT: begin
        p2x = K58;
      end
      MODE_EASE_IN_OUT: begin
        p1x = K42;
        p2x = K58;
      end
      MODE_BEZIER: begin
        p1x = ACC_W'(clamp01(ctrl_x1));
        p2x = ACC_W'(clamp01(ctrl_x2));
        p1y = ACC_W'(ctrl_y1);
        p2y = ACC_W'(ctrl_y2);
      end
      default: begin
      end
    endcase
    cx_c = (p1x <<< 1) + p1x;
    bx_c = ((p2x <<< 1) + p2x) - ((p1x <<< 2) + (p1x <<< 1));
    ax_c = FX_ONE + ((p1x <<< 1) + p1x) - ((p2x <<< 1) + p2x);
    cy_c = (p1y <<< 1) + p1y;
    by_c = ((p2y <<< 1) + p2y) - ((p1y <<< 2) + (p1y <<< 1));
    ay_c = FX_ONE + ((p1y <<< 1) + p1y) - ((p2y <<< 1) + p2y);
  end

  // rounded product, ties away from zero
  logic [PROD_W-1:0]       pmag;
  logic [PROD_W-1:0]       pr_sum;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] addend;

  always_comb begin
    pmag   = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    pr_sum = (pmag + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    rnd    = prod_r[PROD_W-1] ? -ACC_W'(pr_sum) : ACC_W'(pr_sum);
    case (cmd.op)
      OP_ADD_XB:  addend = xb_r;
      OP_ADD_XC:  addend = xc_r;
      OP_ADD_2XB: addend = xb_r <<< 1;
      OP_ADD_YB:  addend = yb_r;
      OP_ADD_YC:  addend = yc_r;
      default:    addend = '0;
    endcase
  end

  // divider setup, Newton update and bisection midpoint
  logic [ACC_W-1:0]        err_mag, slope_mag;
  logic [DSH_W-1:0]        rem_ext;
  logic [QB:0]             qmag;
  logic signed [UD_W-1:0]  qs, ud;
  logic signed [U_W-1:0]   u_new;
  logic signed [ACC_W-1:0] t_ext;
  logic                    x_gt;
  logic [LH_W-1:0]         lo_n, hi_n, u_lh;
  logic [LH_W:0]           mid;

  always_comb begin
    err_mag   = err_r[ACC_W-1] ? ACC_W'(-err_r) : ACC_W'(err_r);
    slope_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    rem_ext   = DSH_W'(rem_r);
    qmag      = ovf_r ? (QB+1)'(1) << QB : {1'b0, q_r};
    qs        = qneg_r ? -UD_W'(qmag) : UD_W'(qmag);
    ud        = UD_W'(u_r) - qs;
    if (ud < -UD_W'(FX_ONE)) u_new = -U_W'(FX_ONE);
    else if (ud > UD_W'(FX_ONE <<< 1)) u_new = U_W'(FX_ONE <<< 1);
    else u_new = U_W'(ud);
    t_ext = ACC_W'(t_r);
    x_gt  = acc_r > t_ext;
    u_lh  = LH_W'(u_r);
    lo_n  = x_gt ? lo_r : u_lh;
    hi_n  = x_gt ? u_lh : hi_r;
    mid   = ((LH_W+1)'(lo_n) + (LH_W+1)'(hi_n)) >> 1;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        xa_r    <= ax_c;
        xb_r    <= bx_c;
        xc_r    <= cx_c;
        ya_r    <= ay_c;
        yb_r    <= by_c;
        yc_r    <= cy_c;
        t_r     <= U_W'(t_c);
        u_r     <= U_W'(t_c);
        curve_r <= (mode inside {MODE_EASE_IN, MODE_EASE_OUT, MODE_EASE_IN_OUT,
                                 MODE_BEZIER});
        step_r  <= (mode == MODE_STEP);
      end
      OP_INIT_X:  acc_r <= xa_r;
      OP_INIT_SX: acc_r <= (xa_r <<< 1) + xa_r;
      OP_INIT_Y:  acc_r <= ya_r;
      OP_MUL:     prod_r <= PROD_W'(acc_r) * PROD_W'(u_r);
      OP_ADD_XB, OP_ADD_XC, OP_ADD_2XB, OP_ADD_YB, OP_ADD_YC, OP_ADD_ZERO:
        acc_r <= rnd + addend;
      OP_SAVE_ERR: err_r <= acc_r - t_ext;
      OP_DIV_START: begin
        rem_r  <= {err_mag, FRAC_BITS'(0)};
        dsh_r  <= DSH_W'(slope_mag) << (QB - 1);
        ovf_r  <= DSH_W'({err_mag, FRAC_BITS'(0)}) >= (DSH_W'(slope_mag) << QB);
        qneg_r <= err_r[ACC_W-1] ^ acc_r[ACC_W-1];
        q_r    <= '0;
      end
      OP_DIV_STEP: begin
        if (rem_ext >= dsh_r) begin
          rem_r <= REM_W'(rem_ext - dsh_r);
          q_r   <= {q_r[QB-2:0], 1'b1};
        end else begin
          q_r   <= {q_r[QB-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
      OP_NEWTON_UPD: u_r <= u_new;
      OP_BIS_INIT: begin
        u_r  <= t_r;
        lo_r <= '0;
        hi_r <= LH_W'(FX_ONE);
      end
      OP_BIS_UPD: begin
        lo_r <= lo_n;
        hi_r <= hi_n;
        u_r  <= U_W'(mid);
      end
      OP_OUT_Y: begin
        if (acc_r > OUT_MAX) out_val_r <= OUT_W'(OUT_MAX);
        else if (acc_r < OUT_MIN) out_val_r <= OUT_W'(OUT_MIN);
        else out_val_r <= OUT_W'(acc_r);
      end
      OP_OUT_DIRECT: out_val_r <= step_r ? '0 : OUT_W'(t_r);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT_Y || cmd.op == OP_OUT_DIRECT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.curve      = curve_r;
  assign status.x_eq_t     = (acc_r == t_ext);
  assign status.slope_zero = (acc_r == '0);
  assign status.u_in_range = (u_r >= 0) && (u_r <= U_W'(FX_ONE));
  assign status.out_busy   = out_valid_r && !out_ready;

  assign out_valid   = out_valid_r;
  assign eased_value = out_val_r;

endmodule

// ----- rtl/cbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbe_ctrl
// Sequencer: Horner evaluation phases, Newton iterations with divider,
// bisection fallback and result hand-off.
// ----------------------------------------------------------------------------
module cbe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cbe_pkg::status_t status,
  output cbe_pkg::cmd_t    cmd
);
  import cbe_pkg::*;

  localparam logic [2:0] EVP_LAST = 3'd6;
  localparam logic [2:0] EVS_LAST = 3'd4;

  state_t          state_r, state_nxt;
  logic [2:0]      ph_r, ph_nxt;
  logic [IT_W-1:0] it_r, it_nxt;
  logic [DC_W-1:0] dc_r, dc_nxt;
  logic            bis_r, bis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= '0;
      it_r    <= '0;
      dc_r    <= '0;
      bis_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      it_r    <= it_nxt;
      dc_r    <= dc_nxt;
      bis_r   <= bis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    it_nxt    = it_r;
    dc_nxt    = dc_r;
    bis_nxt   = bis_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.curve) begin
          state_nxt = S_EVX;
          ph_nxt    = '0;
          it_nxt    = '0;
          bis_nxt   = 1'b0;
        end else begin
          state_nxt = S_DIRECT;
        end
      end
      S_DIRECT: begin
        if (!status.out_busy) begin
          cmd.op    = OP_OUT_DIRECT;
          state_nxt = S_IDLE;
        end
      end
      S_EVX, S_EVY: begin
        if (ph_r == '0) cmd.op = (state_r == S_EVX) ? OP_INIT_X : OP_INIT_Y;
        else if (ph_r inside {3'd1, 3'd3, 3'd5}) cmd.op = OP_MUL;
        else if (ph_r == 3'd2) cmd.op = (state_r == S_EVX) ? OP_ADD_XB : OP_ADD_YB;
        else if (ph_r == 3'd4) cmd.op = (state_r == S_EVX) ? OP_ADD_XC : OP_ADD_YC;
        else cmd.op = OP_ADD_ZERO;
        if (ph_r == EVP_LAST) begin
          ph_nxt    = '0;
          state_nxt = (state_r == S_EVX) ? S_XCHK : S_DONE;
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      S_XCHK: begin
        if (!bis_r) begin
          if (status.x_eq_t) begin
            state_nxt = status.u_in_range ? S_EVY : S_BINIT;
          end else begin
            cmd.op    = OP_SAVE_ERR;
            state_nxt = S_EVS;
          end
        end else if (status.x_eq_t) begin
          state_nxt = S_EVY;
        end else begin
          cmd.op = OP_BIS_UPD;
          if (it_r == IT_W'(BISECT_STEPS - 1)) begin
            state_nxt = S_EVY;
          end else begin
            it_nxt    = it_r + 1'b1;
            state_nxt = S_EVX;
          end
        end
      end
      S_EVS: begin
        if (ph_r == '0) cmd.op = OP_INIT_SX;
        else if (ph_r inside {3'd1, 3'd3}) cmd.op = OP_MUL;
        else if (ph_r == 3'd2) cmd.op = OP_ADD_2XB;
        else cmd.op = OP_ADD_XC;
        if (ph_r == EVS_LAST) begin
          ph_nxt    = '0;
          state_nxt = S_SCHK;
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      S_SCHK: begin
        if (status.slope_zero) begin
          state_nxt = S_BINIT;
        end else begin
          cmd.op    = OP_DIV_START;
          dc_nxt    = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (dc_r == DC_W'(QB - 1)) begin
          state_nxt = S_NUPD;
        end else begin
          dc_nxt = dc_r + 1'b1;
        end
      end
      S_NUPD: begin
        cmd.op = OP_NEWTON_UPD;
        if (it_r == IT_W'(NEWTON_STEPS - 1)) begin
          state_nxt = S_BINIT;
        end else begin
          it_nxt    = it_r + 1'b1;
          state_nxt = S_EVX;
        end
      end
      S_BINIT: begin
        cmd.op    = OP_BIS_INIT;
        it_nxt    = '0;
        bis_nxt   = 1'b1;
        ph_nxt    = '0;
        state_nxt = S_EVX;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.op    = OP_OUT_Y;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
